>>> rtl/fbc_pkg.sv
// fbc_pkg: shared types and constants for the frustum box cull block.
// Holds the box and plane word layouts and the register index codes.
// No dependencies.
`default_nettype none

package fbc_pkg;

  localparam int COORD_W    = 16;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int FRAC_BITS  = 12;
  localparam int PLANE_REGS = 6;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int IDX_W      = 3;
  localparam int BOX_W      = 6 * COORD_W;
  localparam int OUT_W      = 8;

  typedef enum logic [IDX_W-1:0] {
    REG_PLANE_LEFT   = 3'd0,
    REG_PLANE_RIGHT  = 3'd1,
    REG_PLANE_BOTTOM = 3'd2,
    REG_PLANE_TOP    = 3'd3,
    REG_PLANE_NEAR   = 3'd4,
    REG_PLANE_FAR    = 3'd5
  } reg_idx_t;

  // nx in bits 63:48 down to offset in bits 15:0
  typedef struct packed {
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] offset;
  } plane_t;

  // max_z in the top bits, min_x in the bottom bits, as on the stream
  typedef struct packed {
    logic signed [COORD_W-1:0] max_z;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_x;
  } box_t;

endpackage

`default_nettype wire

>>> rtl/fbc_cfg_regs.sv
// fbc_cfg_regs: APB register file holding the six frustum planes.
// Depends on fbc_pkg.
`default_nettype none

module fbc_cfg_regs (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         psel,
  input  logic                                         penable,
  input  logic                                         pwrite,
  input  logic [fbc_pkg::CFG_ADDR_W-1:0]               paddr,
  input  logic [fbc_pkg::CFG_DATA_W-1:0]               pwdata,
  output logic [fbc_pkg::CFG_DATA_W-1:0]               prdata,
  output logic                                         pready,
  output fbc_pkg::plane_t [fbc_pkg::PLANE_REGS-1:0]    planes
);
  import fbc_pkg::*;

  reg_idx_t idx;
  logic     hit;
  logic     wr;

  // registers sit on 8-byte steps
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
  assign hit    = (idx <= REG_PLANE_FAR);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign prdata = hit ? CFG_DATA_W'(planes[idx]) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      planes <= '0;
    end else if (wr && hit) begin
      planes[idx] <= plane_t'(pwdata);
    end
  end

endmodule

`default_nettype wire

>>> rtl/fbc_plane_lane.sv
// fbc_plane_lane: one plane test; registers the six axis products, then
// picks the larger product per axis and checks the best corner is inside.
// Depends on fbc_pkg.
`default_nettype none

module fbc_plane_lane (
  input  logic            clk,
  input  logic            en,
  input  fbc_pkg::box_t   box,
  input  fbc_pkg::plane_t plane,
  output logic            keep
);
  import fbc_pkg::*;

  logic signed [PROD_W-1:0] lo_x_next, hi_x_next, lo_y_next, hi_y_next;
  logic signed [PROD_W-1:0] lo_z_next, hi_z_next;
  logic signed [PROD_W-1:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  logic signed [PROD_W-1:0] best_x, best_y, best_z;
  logic signed [SUM_W-1:0]  bias;
  logic signed [SUM_W-1:0]  sum;

  assign lo_x_next = box.min_x * plane.nx;
  assign hi_x_next = box.max_x * plane.nx;
  assign lo_y_next = box.min_y * plane.ny;
  assign hi_y_next = box.max_y * plane.ny;
  assign lo_z_next = box.min_z * plane.nz;
  assign hi_z_next = box.max_z * plane.nz;

  always_ff @(posedge clk) begin
    if (en) begin
      lo_x <= lo_x_next;
      hi_x <= hi_x_next;
      lo_y <= lo_y_next;
      hi_y <= hi_y_next;
      lo_z <= lo_z_next;
      hi_z <= hi_z_next;
    end
  end

  // the best of eight corners is the per-axis best, the sum being separable
  assign best_x = (hi_x > lo_x) ? hi_x : lo_x;
  assign best_y = (hi_y > lo_y) ? hi_y : lo_y;
  assign best_z = (hi_z > lo_z) ? hi_z : lo_z;

  assign bias = SUM_W'(plane.offset) <<< FRAC_BITS;
  assign sum  = SUM_W'(best_x) + SUM_W'(best_y) + SUM_W'(best_z) + bias;
  assign keep = !sum[SUM_W-1] && (sum != '0);

endmodule

`default_nettype wire

>>> rtl/frustum_box_cull.sv
// frustum_box_cull: user guide. One axis-aligned box word enters on the slave
// stream and one visibility word leaves on the master stream, in order. The
// block takes a box in every cycle, stalls aside, and each box passes the input
// register, the product register and the result register before it leaves.
// The three stages each hold one word and ripple ready backwards, so the
// block keeps taking boxes while a result waits, as long as a stage is free.
// Planes are written over APB at byte address 8*i (left, right, bottom, top,
// near, far); write them only while no box is in flight. With planes left at
// zero every box is culled. Depends on fbc_pkg, fbc_cfg_regs, fbc_plane_lane.
`default_nettype none

module frustum_box_cull #(
  parameter int NUM_PLANES = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  // APB configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fbc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [fbc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [fbc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  // box stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata, low to high: min_x, min_y, min_z, max_x, max_y, max_z
  input  logic [fbc_pkg::BOX_W-1:0]       s_tdata,
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata, low to high: visible, then seven zero bits
  output logic [fbc_pkg::OUT_W-1:0]       m_tdata
);
  import fbc_pkg::*;

  plane_t [PLANE_REGS-1:0] planes;
  box_t                    box1;
  logic                    v1, v2, v3;
  logic                    r2, r3;
  logic [NUM_PLANES-1:0]   keep;
  logic                    visible;

  fbc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .planes  (planes)
  );

  // ready ripples back: a stage may load when empty or when it drains
  assign r3       = !v3 || m_tready;
  assign r2       = !v2 || r3;
  assign s_tready = !v1 || r2;

  // stage 1: box register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      box1 <= box_t'(s_tdata);
    end
  end

  // stage 2: product registers inside each plane lane
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    fbc_plane_lane u_lane (
      .clk   (clk),
      .en    (r2),
      .box   (box1),
      .plane (planes[p]),
      .keep  (keep[p])
    );
  end

  // stage 3: result register; visible only if every tested plane keeps the box
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      visible <= &keep;
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = {{(OUT_W-1){1'b0}}, visible};

  // an accepted box is held in stage 1
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v1)
    else $error("accepted box word not held in stage 1");

  // a blocked box stays put until stage 2 frees up
  a_box_holds: assert property (@(posedge clk) disable iff (rst)
    v1 && !r2 |=> v1 && $stable(box1))
    else $error("stage 1 box word lost under stall");

  // a product word moves on into the result stage when it may
  a_stage2_moves: assert property (@(posedge clk) disable iff (rst)
    v2 && r3 |=> v3)
    else $error("stage 2 word dropped");

  // no result word appears from an empty stage 2
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !v2 |=> !m_tvalid)
    else $error("result word invented");

endmodule

`default_nettype wire
